// ===== rtl/scatd_pkg.sv =====
`default_nettype none
package scatd_pkg;

    localparam int WAYS_LOG2 = 3;
    localparam int NUM_WAYS  = 1 << WAYS_LOG2;
    localparam int SET_BITS  = 7;
    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int LINE_BITS = 6;
    localparam int ADDR_BITS = 27;
    localparam int TAG_BITS  = ADDR_BITS - SET_BITS - LINE_BITS;
    localparam int FILL_BITS = ADDR_BITS - LINE_BITS;
    localparam int LFSR_BITS = 16;

    localparam logic [LFSR_BITS-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [LFSR_BITS-1:0] SEED_RESET = 16'd44257;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [ADDR_BITS-1:0] address;
    } access_t;

    typedef struct packed {
        logic                 hit;
        logic [2:0]           way;
        logic                 fill_needed;
        logic [FILL_BITS-1:0] fill_line_address;
    } result_t;

    // One set: valid bits and tags of all ways, stored as one memory row.
    typedef struct packed {
        logic [NUM_WAYS-1:0]                valid;
        logic [NUM_WAYS-1:0][TAG_BITS-1:0]  tag;
    } row_t;

    typedef struct packed {
        logic                 hit;
        logic                 full;
        logic [WAYS_LOG2-1:0] hit_way;
        logic [WAYS_LOG2-1:0] free_way;
    } match_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Galois step, shift right.
    function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] v);
        logic [LFSR_BITS-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/scatd_row_ram.sv =====
`default_nettype none
module scatd_row_ram (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 rd_en,
    input  wire  [scatd_pkg::SET_BITS-1:0]      rd_set,
    output scatd_pkg::row_t                     rd_row,
    output logic                                rd_live,
    input  wire                                 wr_en,
    input  wire  [scatd_pkg::SET_BITS-1:0]      wr_set,
    input  scatd_pkg::row_t                     wr_row
);
    import scatd_pkg::*;

    row_t                mem [NUM_SETS];
    logic [NUM_SETS-1:0] live_reg;
    row_t                rd_row_reg;
    logic                rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_set];
        end
    end

    // Per-set flag: a row never written reads as all ways invalid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                live_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_live_reg <= live_reg[rd_set];
            end
        end
    end

    assign rd_row  = rd_row_reg;
    assign rd_live = rd_live_reg;

endmodule
`default_nettype wire

// ===== rtl/scatd_match.sv =====
`default_nettype none
module scatd_match (
    input  scatd_pkg::row_t                     row,
    input  wire  [scatd_pkg::TAG_BITS-1:0]      tag,
    output scatd_pkg::match_t                   match
);
    import scatd_pkg::*;

    always_comb
    begin
        match = '0;
        match.full = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (row.valid[w])
            begin
                // lowest matching way wins
                if (!match.hit && row.tag[w] == tag)
                begin
                    match.hit     = 1'b1;
                    match.hit_way = w[WAYS_LOG2-1:0];
                end
            end
            else
            begin
                // highest invalid way wins
                match.full     = 1'b0;
                match.free_way = w[WAYS_LOG2-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/set_assoc_cache_tag_directory_core.sv =====
`default_nettype none
// An accepted item enters the lookup state, where the set row read on accept is
// matched; done and the result are then registered. No new item is taken while
// busy in lookup, as the set is read, then written back over one port pair.
// Reset: all sets read as invalid at once via per-set flags, no clearing pass;
// the LFSR loads the seed reset value. The receiver cannot stall results.
module set_assoc_cache_tag_directory_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  scatd_pkg::access_t                  access,
    output logic                                done,
    output scatd_pkg::result_t                  result,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [scatd_pkg::LFSR_BITS-1:0]     cfg_data
);
    import scatd_pkg::*;

    state_t               state_reg, state_next;
    access_t              req_reg;
    logic [LFSR_BITS-1:0] lfsr_reg, lfsr_next_val;
    result_t              result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 accept;
    row_t                 rd_row;
    logic                 rd_live;
    row_t                 row_eff;
    row_t                 wr_row;
    logic                 wr_en;
    match_t               match;
    logic [TAG_BITS-1:0]  req_tag;
    logic [SET_BITS-1:0]  req_set;
    logic [LFSR_BITS-1:0] lfsr_step;
    logic [WAYS_LOG2-1:0] victim;

    assign busy      = (state_reg == ST_LOOKUP);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign req_tag = req_reg.address[ADDR_BITS-1 -: TAG_BITS];
    assign req_set = req_reg.address[LINE_BITS +: SET_BITS];

    // Set memory: read on accept, written back in the lookup cycle on a read miss.
    scatd_row_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_set  (access.address[LINE_BITS +: SET_BITS]),
        .rd_row  (rd_row),
        .rd_live (rd_live),
        .wr_en   (wr_en),
        .wr_set  (req_set),
        .wr_row  (wr_row)
    );

    // A set never written has all ways invalid; its tags are don't-care.
    always_comb
    begin
        row_eff       = rd_row;
        row_eff.valid = rd_live ? rd_row.valid : '0;
    end

    scatd_match u_match (
        .row   (row_eff),
        .tag   (req_tag),
        .match (match)
    );

    assign lfsr_step = lfsr_next(lfsr_reg);
    assign victim    = match.full ? lfsr_step[WAYS_LOG2-1:0] : match.free_way;

    always_comb
    begin
        state_next    = state_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        lfsr_next_val = lfsr_reg;
        wr_en         = 1'b0;
        wr_row        = row_eff;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '0;
                if (match.hit)
                begin
                    result_next.hit = 1'b1;
                    result_next.way = match.hit_way;
                end
                else if (req_reg.opcode == OP_READ)
                begin
                    // read miss: allocate, LFSR steps only when the set is full
                    wr_en                     = 1'b1;
                    wr_row.valid[victim]      = 1'b1;
                    wr_row.tag[victim]        = req_tag;
                    if (match.full)
                    begin
                        lfsr_next_val = lfsr_step;
                    end
                    result_next.way               = victim;
                    result_next.fill_needed       = 1'b1;
                    result_next.fill_line_address = req_reg.address[ADDR_BITS-1:LINE_BITS];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // seed write reloads the LFSR; the user must do it only while idle, the block does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            lfsr_next_val = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lfsr_reg  <= SEED_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg  <= lfsr_next_val;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= access;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
